### rtl/core/etl_pkg.sv
// Shared types and constants for the expression token lexer.
package etl_pkg;

   localparam int MAX_TOKEN_LEN_DEFAULT = 255;
   localparam int LEN_W = 8;

   localparam logic [2:0] KIND_CONST = 3'd0;
   localparam logic [2:0] KIND_VAR   = 3'd1;
   localparam logic [2:0] KIND_FUNC  = 3'd2;
   localparam logic [2:0] KIND_OP    = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_NUM  = 2'd1;
   localparam logic [1:0] STATUS_BAD_NAME = 2'd2;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [2:0]       kind;
      logic [7:0]       op;
      logic [LEN_W-1:0] len;
      logic [1:0]       status;
   } rec_type;

   typedef struct packed {
      logic [1:0]        count;
      rec_type [2:0]     rec;
   } bundle_type;

endpackage

### rtl/core/etl_scan.sv
// Token state and the per-character record builder of the expression token lexer.
module etl_scan #(
   parameter int MAX_TOKEN_LEN = etl_pkg::MAX_TOKEN_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_code,
   input  logic                end_of_expr,
   output etl_pkg::bundle_type bundle
);

   localparam logic [etl_pkg::LEN_W-1:0] LEN_CAP =
      etl_pkg::LEN_W'((MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN);

   logic [etl_pkg::LEN_W-1:0] pend_len_ff, pend_len_in;
   logic                      numeric_ff, numeric_in;
   logic                      dot_ff, dot_in;
   logic                      sdig_ff, sdig_in;
   logic                      extra_ff, extra_in;
   logic                      halted_ff, halted_in;
   logic [1:0]                err_ff, err_in;

   always_comb begin
      logic                  is_space;
      logic                  is_sep;
      logic                  is_digit;
      logic                  func;
      logic [1:0]            n;
      logic [1:0]            err;
      etl_pkg::rec_type [2:0] recs;

      is_space = (char_code inside {[etl_pkg::CH_TAB:etl_pkg::CH_CR], etl_pkg::CH_SPACE});
      is_sep   = (char_code inside {etl_pkg::CH_LPAREN, etl_pkg::CH_RPAREN, etl_pkg::CH_PLUS,
                                    etl_pkg::CH_MINUS, etl_pkg::CH_STAR, etl_pkg::CH_SLASH,
                                    etl_pkg::CH_COMMA});
      is_digit = (char_code inside {[etl_pkg::CH_ZERO:etl_pkg::CH_NINE]});
      func     = 1'b0;
      n        = 2'd0;
      err      = etl_pkg::STATUS_OK;
      recs     = '0;

      pend_len_in = pend_len_ff;
      numeric_in  = numeric_ff;
      dot_in      = dot_ff;
      sdig_in     = sdig_ff;
      extra_in    = extra_ff;
      halted_in   = halted_ff;
      err_in      = err_ff;

      if (!halted_ff && !is_space) begin
         if (is_sep) begin
            if (pend_len_in != '0) begin
               if (!numeric_in && sdig_in) begin
                  err = etl_pkg::STATUS_BAD_NAME;
               end else if (extra_in) begin
                  err = etl_pkg::STATUS_BAD_NUM;
               end
               if (err != etl_pkg::STATUS_OK) begin
                  err_in    = err;
                  halted_in = 1'b1;
               end else begin
                  recs[n].kind = numeric_in ? etl_pkg::KIND_CONST : etl_pkg::KIND_VAR;
                  if (!numeric_in && (char_code == etl_pkg::CH_LPAREN)) begin
                     recs[n].kind = etl_pkg::KIND_FUNC;
                     func         = 1'b1;
                  end
                  recs[n].len = pend_len_in;
                  n           = n + 2'd1;
               end
               pend_len_in = '0;
               numeric_in  = 1'b1;
               dot_in      = 1'b0;
               sdig_in     = 1'b0;
               extra_in    = 1'b0;
            end
            if (!func) begin
               recs[n].kind = etl_pkg::KIND_OP;
               recs[n].op   = char_code;
               recs[n].len  = etl_pkg::LEN_W'(1);
               n            = n + 2'd1;
            end
         end else begin
            if (pend_len_in == '0) begin
               sdig_in = is_digit;
            end
            if (char_code == etl_pkg::CH_DOT) begin
               if (numeric_in) begin
                  if (dot_in) begin
                     extra_in = 1'b1;
                  end else begin
                     dot_in = 1'b1;
                  end
               end
            end else if (!is_digit) begin
               numeric_in = 1'b0;
            end
            if (pend_len_in < LEN_CAP) begin
               pend_len_in = pend_len_in + etl_pkg::LEN_W'(1);
            end
         end
      end

      if (end_of_expr) begin
         if (!halted_in && (pend_len_in != '0)) begin
            if (!numeric_in && sdig_in) begin
               err_in = etl_pkg::STATUS_BAD_NAME;
            end else if (extra_in) begin
               err_in = etl_pkg::STATUS_BAD_NUM;
            end else begin
               recs[n].kind = numeric_in ? etl_pkg::KIND_CONST : etl_pkg::KIND_VAR;
               recs[n].len  = pend_len_in;
               n            = n + 2'd1;
            end
         end
         recs[n].kind   = etl_pkg::KIND_END;
         recs[n].status = err_in;
         n              = n + 2'd1;
         pend_len_in = '0;
         numeric_in  = 1'b1;
         dot_in      = 1'b0;
         sdig_in     = 1'b0;
         extra_in    = 1'b0;
         halted_in   = 1'b0;
         err_in      = etl_pkg::STATUS_OK;
      end

      bundle.count = n;
      bundle.rec   = recs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_len_ff <= '0;
         numeric_ff  <= 1'b1;
         dot_ff      <= 1'b0;
         sdig_ff     <= 1'b0;
         extra_ff    <= 1'b0;
         halted_ff   <= 1'b0;
         err_ff      <= etl_pkg::STATUS_OK;
      end else if (accept) begin
         pend_len_ff <= pend_len_in;
         numeric_ff  <= numeric_in;
         dot_ff      <= dot_in;
         sdig_ff     <= sdig_in;
         extra_ff    <= extra_in;
         halted_ff   <= halted_in;
         err_ff      <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_halt_has_code: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (err_ff != etl_pkg::STATUS_OK))
      else $error("Halted without an error code.");
   a_halt_no_token: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (pend_len_ff == '0))
      else $error("Pending token kept while halted.");
   a_extra_needs_dot: assert property (@(posedge clock) disable iff (reset)
      extra_ff |-> (dot_ff && (pend_len_ff != '0)))
      else $error("Extra dot flagged without a first dot.");
`endif

endmodule

### rtl/core/etl_emit.sv
// Record buffer that hands the records of one character out one transfer at a time.
module etl_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  etl_pkg::bundle_type bundle,
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_token_kind,
   output logic [7:0]          rsp_op_char,
   output logic [7:0]          rsp_token_length,
   output logic [1:0]          rsp_status,
   output logic                rsp_last_of_run
);

   logic                valid_ff;
   logic [1:0]          idx_ff;
   etl_pkg::bundle_type bundle_ff;
   etl_pkg::rec_type    cur;
   logic                is_last;
   logic                xfer;

   assign cur      = bundle_ff.rec[idx_ff];
   assign is_last  = (idx_ff == (bundle_ff.count - 2'd1));
   assign xfer     = valid_ff && !rsp_stall;
   assign can_take = !valid_ff || (xfer && is_last);

   assign rsp_valid        = valid_ff;
   assign rsp_token_kind   = cur.kind;
   assign rsp_op_char      = cur.op;
   assign rsp_token_length = cur.len;
   assign rsp_status       = cur.status;
   assign rsp_last_of_run  = is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (xfer) begin
         if (is_last) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end

`ifndef SYNTHESIS
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (idx_ff < bundle_ff.count))
      else $error("Record index beyond the record count.");
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (!reset && xfer && !is_last) |=> (rsp_valid && (idx_ff == $past(idx_ff) + 2'd1)))
      else $error("Run of records broken before its last record.");
   a_load_nonempty: assert property (@(posedge clock) disable iff (reset)
      load |-> ((bundle.count != 2'd0) && can_take))
      else $error("Buffer loaded while busy or with no records.");
`endif

endmodule

### rtl/core/expression_token_lexer.sv
// Top level of the expression token lexer.
// The req channel carries one expression character per transfer, with
// req_end_of_expr marking the final character of an expression. The rsp
// channel carries the records that each character causes: constant,
// variable and function-call tokens with their lengths, operator records
// for separators, and an end record with the status of the expression.
// rsp_last_of_run marks the last record caused by one character.
// The first record of a character is registered and is on rsp in the cycle
// after its transfer. A character that causes several records keeps req
// stalled until its last record is taken. While rsp is not stalled,
// characters that cause at most one record go through at one per cycle;
// whitespace and ignored characters cause no records and never occupy the
// record buffer. The limit is the single record buffer, which hands out
// one record per cycle. While rsp is stalled, the current record holds
// and req is stalled as well. Reset clears the token state, the error
// state and the buffer; req is taken from the first cycle after reset.
module expression_token_lexer #(
   parameter int MAX_TOKEN_LEN = etl_pkg::MAX_TOKEN_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_op_char,
   output logic [7:0] rsp_token_length,
   output logic [1:0] rsp_status,
   output logic       rsp_last_of_run
);

   logic                accept;
   logic                can_take;
   logic                load;
   etl_pkg::bundle_type bundle;

   assign req_stall = !can_take;
   assign accept    = req_valid && can_take;
   assign load      = accept && (bundle.count != 2'd0);

   etl_scan #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .char_code   (req_char_code),
      .end_of_expr (req_end_of_expr),
      .bundle      (bundle)
   );

   etl_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .bundle           (bundle),
      .can_take         (can_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_op_char      (rsp_op_char),
      .rsp_token_length (rsp_token_length),
      .rsp_status       (rsp_status),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
